// ----- hdl/aho_corasick_automaton_unit_assert.svh -----
// aho_corasick_automaton_unit_assert.svh: assertion macros for the automaton unit
// expects clk and arst_n in the scope of use
`ifndef AHO_CORASICK_AUTOMATON_UNIT_ASSERT_SVH
`define AHO_CORASICK_AUTOMATON_UNIT_ASSERT_SVH

// condition holds at every edge out of reset
`define ACA_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// antecedent implies consequent in the next cycle
`define ACA_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hdl/aca_pkg.sv -----
// aca_pkg.sv: shared constants and codes for the aho-corasick automaton unit
// no dependencies
package aca_pkg;

	localparam int MAX_NODES_DEF = 1024;
	localparam int ALPHABET_DEF  = 26;

	localparam int NODE_PORT_W = 10;
	localparam int SYM_PORT_W  = 5;

	typedef enum logic [1:0] {
		CMD_INSERT = 2'd0,
		CMD_GOTO   = 2'd1,
		CMD_LINK   = 2'd2,
		CMD_NONE   = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_FULL   = 2'd1,
		ST_NO_NODE = 2'd2,
		ST_UNUSED = 2'd3
	} status_t;

endpackage

// ----- hdl/aho_corasick_automaton_unit.sv -----
// aho_corasick_automaton_unit.sv: aho-corasick trie with memoized goto and suffix links
// depends on aca_pkg and aho_corasick_automaton_unit_assert.svh
//
// One command beat is taken when start is high and busy is low; exactly one result beat
// follows, shown for one cycle with done high, and the receiver cannot stall it. After
// reset the unit clears the root row before it takes a beat.
// An insert answers after the ICALL and INS states, and creating a node then keeps busy
// high while the new row of the transition memory is cleared.
// Queries on nodes not yet created and the unused command answer on the next cycle.
// A goto or link query walks suffix links and parents through the transition memory,
// the node memory and a frame stack: each lookup passes a call and a result state, a
// returning lookup passes S_RET, and each unwound frame passes S_POP twice, first to
// resume with a goto lookup and then to store the memoized result.
module aho_corasick_automaton_unit
	import aca_pkg::*;
#(
	parameter int MAX_NODES = MAX_NODES_DEF,
	parameter int ALPHABET  = ALPHABET_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	output logic                   busy,
	input  logic [1:0]             cmd,
	input  logic [NODE_PORT_W-1:0] node,
	input  logic [SYM_PORT_W-1:0]  symbol,
	input  logic                   last,
	output logic                   done,
	output logic [NODE_PORT_W-1:0] result_node,
	output logic [1:0]             status
);

	localparam int NW        = (MAX_NODES > 2) ? $clog2(MAX_NODES) : 1;
	localparam int CW        = NW + 1;
	localparam int SW        = (ALPHABET > 2) ? $clog2(ALPHABET) : 1;
	localparam int AAW       = $clog2(MAX_NODES * ALPHABET);
	localparam int STK_DEPTH = 2 * MAX_NODES;
	localparam int SAW       = $clog2(STK_DEPTH);
	localparam int SPW       = SAW + 1;
	localparam int CMPW      = (CW > NODE_PORT_W) ? CW : NODE_PORT_W;

	typedef struct packed {
		logic          cv;
		logic [NW-1:0] cidx;
		logic          gv;
		logic [NW-1:0] gidx;
	} trans_t;

	typedef struct packed {
		logic          lv;
		logic [NW-1:0] lidx;
		logic [NW-1:0] par;
		logic [SW-1:0] ltr;
	} node_ent_t;

	typedef struct packed {
		logic          is_link;
		logic          ph;
		logic [NW-1:0] v;
		logic [SW-1:0] c;
		logic [NW-1:0] p;
	} frame_t;

	typedef enum logic [10:0] {
		S_INIT  = 11'b000_0000_0001,
		S_IDLE  = 11'b000_0000_0010,
		S_ICALL = 11'b000_0000_0100,
		S_INS   = 11'b000_0000_1000,
		S_CLR   = 11'b000_0001_0000,
		S_GCALL = 11'b000_0010_0000,
		S_GRES  = 11'b000_0100_0000,
		S_LCALL = 11'b000_1000_0000,
		S_LRES  = 11'b001_0000_0000,
		S_RET   = 11'b010_0000_0000,
		S_POP   = 11'b100_0000_0000
	} state_t;

	state_t          state_q;
	logic [CW-1:0]   count_q;
	logic [NW-1:0]   cursor_q;
	logic [NW-1:0]   cur_v_q;
	logic [SW-1:0]   cur_c_q;
	logic            last_q;
	logic [NW-1:0]   ret_q;
	logic [SPW-1:0]  sp_q;
	logic [NW-1:0]   clr_node_q;
	logic [SW-1:0]   clr_i_q;
	logic            done_q;
	logic [NW-1:0]   res_q;
	status_t         status_q;

	trans_t    a_mem [MAX_NODES*ALPHABET];
	node_ent_t b_mem [MAX_NODES];
	frame_t    stk_mem [STK_DEPTH];

	trans_t    a_rd, a_wd;
	node_ent_t b_rd, b_wd;
	frame_t    stk_rd, stk_wd;
	logic      a_we, b_we, stk_we;
	logic [AAW-1:0] a_addr;
	logic [NW-1:0]  a_v, b_addr;
	logic [SW-1:0]  a_c;
	logic [SAW-1:0] stk_addr;
	logic [SPW-1:0] sp_m1;
	logic [SW-1:0]  sym_sat;
	logic [NW-1:0]  new_n;
	logic           full;
	logic           accept;
	logic           node_bad;

	assign busy     = (state_q != S_IDLE);
	assign accept   = start && !busy;
	assign sp_m1    = sp_q - 1'b1;
	assign new_n    = count_q[NW-1:0];
	assign full     = (count_q == CW'(MAX_NODES));
	assign sym_sat  = (32'(symbol) >= 32'(ALPHABET)) ? SW'(ALPHABET - 1) : SW'(symbol);
	assign node_bad = (CMPW'(node) >= CMPW'(count_q));

	assign done        = done_q;
	assign result_node = NODE_PORT_W'(res_q);
	assign status      = status_q;

	// memory address and write selection
	always_comb begin
		a_v      = cur_v_q;
		a_c      = cur_c_q;
		a_we     = 1'b0;
		a_wd     = '0;
		b_addr   = cur_v_q;
		b_we     = 1'b0;
		b_wd     = '0;
		stk_addr = sp_m1[SAW-1:0];
		stk_we   = 1'b0;
		stk_wd   = stk_rd;
		case (state_q)
			S_INIT, S_CLR: begin
				a_v    = clr_node_q;
				a_c    = clr_i_q;
				a_we   = 1'b1;
				b_addr = '0;
				b_we   = (state_q == S_INIT);
			end
			S_INS: begin
				if (!a_rd.cv && !full) begin
					a_we   = 1'b1;
					a_wd   = '{cv: 1'b1, cidx: new_n, gv: a_rd.gv, gidx: a_rd.gidx};
					b_addr = new_n;
					b_we   = 1'b1;
					b_wd   = '{lv: 1'b0, lidx: '0, par: cur_v_q, ltr: cur_c_q};
				end
			end
			S_GRES: begin
				if (!a_rd.gv && (a_rd.cv || cur_v_q == '0)) begin
					a_we = 1'b1;
					a_wd = '{cv: a_rd.cv, cidx: a_rd.cidx, gv: 1'b1,
						gidx: a_rd.cv ? a_rd.cidx : '0};
				end else if (!a_rd.gv) begin
					stk_addr = sp_q[SAW-1:0];
					stk_we   = 1'b1;
					stk_wd   = '{is_link: 1'b0, ph: 1'b0, v: cur_v_q, c: cur_c_q, p: '0};
				end
			end
			S_LRES: begin
				if (!b_rd.lv && b_rd.par == '0) begin
					b_we = 1'b1;
					b_wd = '{lv: 1'b1, lidx: '0, par: b_rd.par, ltr: b_rd.ltr};
				end else if (!b_rd.lv) begin
					stk_addr = sp_q[SAW-1:0];
					stk_we   = 1'b1;
					stk_wd   = '{is_link: 1'b1, ph: 1'b0, v: cur_v_q, c: b_rd.ltr,
						p: b_rd.par};
				end
			end
			S_POP: begin
				if (!stk_rd.ph) begin
					stk_we    = 1'b1;
					stk_wd.ph = 1'b1;
				end else if (!stk_rd.is_link) begin
					a_v  = stk_rd.v;
					a_c  = stk_rd.c;
					a_we = 1'b1;
					a_wd = '{cv: 1'b0, cidx: '0, gv: 1'b1, gidx: ret_q};
				end else begin
					b_addr = stk_rd.v;
					b_we   = 1'b1;
					b_wd   = '{lv: 1'b1, lidx: ret_q, par: stk_rd.p, ltr: stk_rd.c};
				end
			end
			default: begin
			end
		endcase
		a_addr = AAW'(a_v) * AAW'(ALPHABET) + AAW'(a_c);
	end

	always_ff @(posedge clk) begin
		if (a_we) a_mem[a_addr] <= a_wd;
		a_rd <= a_mem[a_addr];
	end

	always_ff @(posedge clk) begin
		if (b_we) b_mem[b_addr] <= b_wd;
		b_rd <= b_mem[b_addr];
	end

	always_ff @(posedge clk) begin
		if (stk_we) stk_mem[stk_addr] <= stk_wd;
		stk_rd <= stk_mem[stk_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_INIT;
			count_q    <= CW'(1);
			cursor_q   <= '0;
			cur_v_q    <= '0;
			cur_c_q    <= '0;
			last_q     <= 1'b0;
			ret_q      <= '0;
			sp_q       <= '0;
			clr_node_q <= '0;
			clr_i_q    <= '0;
			done_q     <= 1'b0;
			res_q      <= '0;
			status_q   <= ST_OK;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_INIT, S_CLR: begin
					clr_i_q <= clr_i_q + 1'b1;
					if (clr_i_q == SW'(ALPHABET - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						cur_c_q <= sym_sat;
						last_q  <= last;
						case (cmd)
							CMD_INSERT: begin
								cur_v_q <= cursor_q;
								state_q <= S_ICALL;
							end
							CMD_GOTO, CMD_LINK: begin
								if (node_bad) begin
									done_q   <= 1'b1;
									res_q    <= '0;
									status_q <= ST_NO_NODE;
								end else begin
									cur_v_q <= NW'(node);
									state_q <= (cmd == CMD_GOTO) ? S_GCALL : S_LCALL;
								end
							end
							default: begin
								done_q   <= 1'b1;
								res_q    <= cursor_q;
								status_q <= ST_OK;
							end
						endcase
					end
				end
				S_ICALL: state_q <= S_INS;
				S_INS: begin
					done_q   <= 1'b1;
					status_q <= ST_OK;
					state_q  <= S_IDLE;
					if (a_rd.cv) begin
						res_q    <= a_rd.cidx;
						cursor_q <= last_q ? '0 : a_rd.cidx;
					end else if (full) begin
						res_q    <= cursor_q;
						status_q <= ST_FULL;
						if (last_q) cursor_q <= '0;
					end else begin
						res_q      <= new_n;
						cursor_q   <= last_q ? '0 : new_n;
						count_q    <= count_q + 1'b1;
						clr_node_q <= new_n;
						clr_i_q    <= '0;
						state_q    <= S_CLR;
					end
				end
				S_GCALL: state_q <= S_GRES;
				S_GRES: begin
					if (a_rd.gv) begin
						ret_q   <= a_rd.gidx;
						state_q <= S_RET;
					end else if (a_rd.cv) begin
						ret_q   <= a_rd.cidx;
						state_q <= S_RET;
					end else if (cur_v_q == '0) begin
						ret_q   <= '0;
						state_q <= S_RET;
					end else begin
						sp_q    <= sp_q + 1'b1;
						state_q <= S_LCALL;
					end
				end
				S_LCALL: state_q <= S_LRES;
				S_LRES: begin
					if (b_rd.lv) begin
						ret_q   <= b_rd.lidx;
						state_q <= S_RET;
					end else if (b_rd.par == '0) begin
						ret_q   <= '0;
						state_q <= S_RET;
					end else begin
						sp_q    <= sp_q + 1'b1;
						cur_v_q <= b_rd.par;
						state_q <= S_LCALL;
					end
				end
				S_RET: begin
					if (sp_q == '0) begin
						done_q   <= 1'b1;
						res_q    <= ret_q;
						status_q <= ST_OK;
						state_q  <= S_IDLE;
					end else begin
						state_q <= S_POP;
					end
				end
				S_POP: begin
					if (!stk_rd.ph) begin
						cur_v_q <= ret_q;
						cur_c_q <= stk_rd.c;
						state_q <= S_GCALL;
					end else begin
						sp_q    <= sp_m1;
						state_q <= S_RET;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`include "aho_corasick_automaton_unit_assert.svh"

	`ACA_NEXT(a_accept_answers, accept, busy || done, "accepted beat neither busy nor answered")
	`ACA_ALWAYS(a_stack_bound, sp_q <= SPW'(STK_DEPTH), "frame stack overflow")
	`ACA_ALWAYS(a_count_range, count_q != '0 && count_q <= CW'(MAX_NODES), "node count out of range")
	`ACA_ALWAYS(a_done_idle, !done || (sp_q == '0 && status != ST_UNUSED), "result with open frames")

endmodule

// ----- tb/sv/testbench.sv -----
// testbench.sv: self-checking bench for the aho-corasick automaton unit
// depends on aca_pkg and aho_corasick_automaton_unit; predicts each result beat and compares
module testbench;
	import aca_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NN = MAX_NODES_DEF;
	localparam int AL = ALPHABET_DEF;
	localparam int LIMIT = 3000000;

	typedef struct packed {
		cmd_t       op;
		logic [9:0] nd;
		logic [4:0] sym;
		logic       lst;
	} cmd_beat_t;

	typedef struct packed {
		logic [9:0] nd;
		logic [1:0] st;
	} res_beat_t;

	logic clk, arst_n, start, last, done, busy;
	logic [1:0] cmd, status;
	logic [9:0] node, result_node;
	logic [4:0] symbol;

	aho_corasick_automaton_unit u_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .cmd(cmd), .node(node),
		.symbol(symbol), .last(last), .done(done), .result_node(result_node), .status(status)
	);

	// predictor state
	int child_t [NN*AL];
	int goto_t [NN*AL];
	int link_t [NN];
	int par_t [NN];
	int let_t [NN];
	int n_nodes, cursor;

	cmd_beat_t pending[$];
	res_beat_t expected[$];
	int errors, n_results, cycles, gap;
	bit stim_done;
	int n_ins, n_goto, n_link, n_full, n_miss;

	function automatic int trie_link(int v);
		int r;
		if (link_t[v] >= 0) return link_t[v];
		r = (par_t[v] == 0) ? 0 : trie_goto(trie_link(par_t[v]), let_t[v]);
		link_t[v] = r;
		return r;
	endfunction

	function automatic int trie_goto(int v, int c);
		int k, r;
		k = v * AL + c;
		if (goto_t[k] >= 0) return goto_t[k];
		if (child_t[k] >= 0) r = child_t[k];
		else if (v == 0) r = 0;
		else r = trie_goto(trie_link(v), c);
		goto_t[k] = r;
		return r;
	endfunction

	function automatic res_beat_t predict(cmd_beat_t b);
		res_beat_t r;
		int s, k;
		s = (b.sym >= AL) ? AL - 1 : b.sym;
		r.nd = '0;
		r.st = ST_OK;
		case (b.op)
			CMD_INSERT: begin
				n_ins++;
				k = cursor * AL + s;
				if (child_t[k] >= 0) cursor = child_t[k];
				else if (n_nodes >= NN) begin
					r.st = ST_FULL;
					n_full++;
				end else begin
					child_t[k] = n_nodes;
					par_t[n_nodes] = cursor;
					let_t[n_nodes] = s;
					cursor = n_nodes;
					n_nodes++;
				end
				r.nd = cursor[9:0];
				if (b.lst) cursor = 0;
			end
			CMD_GOTO, CMD_LINK: begin
				if (b.nd >= n_nodes) begin
					r.st = ST_NO_NODE;
					n_miss++;
				end else if (b.op == CMD_GOTO) begin
					r.nd = 10'(trie_goto(b.nd, s));
					n_goto++;
				end else begin
					r.nd = 10'(trie_link(b.nd));
					n_link++;
				end
			end
			default: r.nd = cursor[9:0];
		endcase
		return r;
	endfunction

	function automatic cmd_beat_t mk(cmd_t op, int nd, int sym, bit lst);
		cmd_beat_t b;
		b.op = op;
		b.nd = nd[9:0];
		b.sym = sym[4:0];
		b.lst = lst;
		return b;
	endfunction

	function automatic void add_item(cmd_beat_t b);
		pending.insert(pending.size(), b);
	endfunction

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		int len, nq, pick;
		foreach (child_t[i]) begin
			child_t[i] = -1;
			goto_t[i] = -1;
		end
		foreach (link_t[i]) begin
			link_t[i] = -1;
			par_t[i] = 0;
			let_t[i] = 0;
		end
		n_nodes = 1;
		cursor = 0;
		// directed part
		add_item(mk(CMD_INSERT, 0, 0, 0));
		add_item(mk(CMD_INSERT, 1023, 1, 0));
		add_item(mk(CMD_INSERT, 0, 31, 1));
		add_item(mk(CMD_INSERT, 0, 1, 0));
		add_item(mk(CMD_INSERT, 0, 25, 1));
		add_item(mk(CMD_INSERT, 0, 0, 1));
		add_item(mk(CMD_GOTO, 3, 0, 0));
		add_item(mk(CMD_GOTO, 5, 1, 0));
		add_item(mk(CMD_GOTO, 0, 31, 1));
		add_item(mk(CMD_LINK, 5, 0, 0));
		add_item(mk(CMD_LINK, 0, 0, 0));
		add_item(mk(CMD_LINK, 2, 0, 0));
		add_item(mk(CMD_GOTO, 1023, 0, 0));
		add_item(mk(CMD_LINK, 900, 0, 1));
		add_item(mk(CMD_INSERT, 0, 2, 0));
		add_item(mk(CMD_NONE, 1023, 31, 1));
		add_item(mk(CMD_NONE, 0, 0, 0));
		add_item(mk(CMD_INSERT, 0, 3, 1));
		// random part: patterns from a small alphabet so links run deep, then queries
		while (pending.size() < 900) begin
			len = $urandom_range(1, 8);
			for (int i = 0; i < len; i++)
				add_item(mk(CMD_INSERT, $urandom, ($urandom_range(0, 9) == 0) ?
					$urandom_range(0, 31) : $urandom_range(0, 3), i == len - 1));
			nq = $urandom_range(0, 6);
			for (int i = 0; i < nq; i++) begin
				pick = $urandom_range(0, 19);
				add_item(mk(pick < 9 ? CMD_GOTO : (pick < 18 ? CMD_LINK : CMD_NONE),
					(pick == 19) ? $urandom_range(0, 1023) : $urandom_range(0, 200),
					($urandom_range(0, 4) == 0) ? $urandom_range(0, 31) : $urandom_range(0, 3),
					1'($urandom)));
			end
		end
		// fill the node table and push past it
		for (int i = 0; i < 950; i++)
			add_item(mk(CMD_INSERT, $urandom, $urandom_range(0, 31),
				$urandom_range(0, 3) == 0));
		for (int i = 0; i < 150; i++)
			add_item(mk($urandom_range(0, 1) ? CMD_GOTO : CMD_LINK,
				$urandom_range(0, 1023), $urandom_range(0, 31), 1'($urandom)));
	end

	initial begin
		arst_n = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1;
	end

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 0;
			cmd <= CMD_INSERT;
			node <= '0;
			symbol <= '0;
			last <= 0;
			gap <= 0;
			stim_done <= 0;
		end else if (start && !busy) begin
			expected.insert(expected.size(),
				predict(cmd_beat_t'({cmd_t'(cmd), node, symbol, last})));
			start <= 0;
			gap <= $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 4);
			if (pending.size() == 0) stim_done <= 1;
		end else if (!start) begin
			if (gap > 0) gap <= gap - 1;
			else if (pending.size() > 0) begin
				cmd_beat_t b;
				b = pending.pop_front();
				start <= 1;
				cmd <= b.op;
				node <= b.nd;
				symbol <= b.sym;
				last <= b.lst;
			end else stim_done <= 1;
		end
	end

	// monitor
	always @(posedge clk) begin
		if (arst_n && done) begin
			res_beat_t e;
			if (expected.size() == 0) begin
				$display("%t unexpected beat: result_node %0d status %0d", $realtime,
					result_node, status);
				errors++;
			end else begin
				e = expected.pop_front();
				n_results++;
				if (result_node !== e.nd) begin
					$display("%t result_node mismatch: expected %0d actual %0d", $realtime,
						e.nd, result_node);
					errors++;
				end
				if (status !== e.st) begin
					$display("%t status mismatch: expected %0d actual %0d", $realtime,
						e.st, status);
					errors++;
				end
			end
		end
	end

	initial begin
		cycles = 0;
		while (!(stim_done && expected.size() == 0 && !start) && cycles < LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		if (cycles >= LIMIT) begin
			$display("[aho_corasick_automaton_unit] ERROR");
			$finish;
		end else begin
			repeat (100) @(posedge clk);
			$display("covered %0d results: %0d inserts (%0d table full), %0d goto, %0d link",
				n_results, n_ins, n_full, n_goto, n_link);
			$display("%0d queries on missing nodes, %0d nodes created", n_miss, n_nodes);
			if (errors == 0 && expected.size() == 0)
				$display("[aho_corasick_automaton_unit] OK");
			else
				$display("[aho_corasick_automaton_unit] ERROR");
			$finish;
		end
	end

endmodule

// ----- sim.f -----
+incdir+hdl
hdl/aca_pkg.sv
hdl/aho_corasick_automaton_unit.sv
tb/sv/testbench.sv
